>>> rtl/cvnd_pkg.sv
// Shared types and constants for the cascaded Von Neumann debiaser.
`timescale 1ns / 1ps
`default_nettype none

package cvnd_pkg;

    // Pass mode register codes; the unused code behaves as normal only
    typedef enum logic [1:0] {
        MODE_CASCADE  = 2'd0,
        MODE_INVERTED = 2'd1,
        MODE_NORMAL   = 2'd2
    } pass_mode_t;

    // Bit count at which a packed byte is complete
    localparam logic [2:0] COUNT_LAST = 3'd7;

    // Number of bit pairs in one byte
    localparam int PAIRS_PER_BYTE = 4;

    // Packing state of one extraction stage
    typedef struct packed {
        logic [7:0] accum;
        logic [2:0] count;
    } stage_state_t;

    // Result of running one byte through a stage
    typedef struct packed {
        logic       done;
        logic [7:0] packed_bits;
    } stage_result_t;

endpackage

`default_nettype wire

>>> rtl/cvnd_stage.sv
// One extraction stage: pair selection and MSB-first packing of one byte.
`timescale 1ns / 1ps
`default_nettype none

module cvnd_stage (
    input  wire logic [7:0]             byte_in,
    input  wire logic                   inverted,
    input  wire cvnd_pkg::stage_state_t state_in,
    output cvnd_pkg::stage_state_t      state_out,
    output cvnd_pkg::stage_result_t     result
);

    // Walk the four pairs, most significant first, and pack kept bits
    always_comb
    begin
        logic [7:0] acc;
        logic [2:0] cnt;
        logic [1:0] pair;
        logic       equal;
        acc = state_in.accum;
        cnt = state_in.count;
        result.done = 1'b0;
        result.packed_bits = 8'h00;
        for (int k = 0; k < cvnd_pkg::PAIRS_PER_BYTE; k++)
        begin
            pair  = byte_in[7 - 2 * k -: 2];
            equal = (pair[1] == pair[0]);
            if (equal == inverted)
            begin
                acc = {acc[6:0], pair[1]};
                if (cnt == cvnd_pkg::COUNT_LAST)
                begin
                    // Byte complete: hand it out and restart packing
                    result.done = 1'b1;
                    result.packed_bits = acc;
                    acc = 8'h00;
                    cnt = 3'd0;
                end
                else
                begin
                    cnt = cnt + 3'd1;
                end
            end
        end
        state_out.accum = acc;
        state_out.count = cnt;
    end

endmodule

`default_nettype wire

>>> rtl/cascaded_von_neumann_debiaser.sv
// Top level of the cascaded Von Neumann debiaser.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------
//  in      | sink      | in_valid / in_stall   | raw_byte[7:0], end_of_data
//  out     | source    | out_valid / out_stall | packed_byte[7:0]
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_pass_mode[1:0]
//
//  One byte is taken per cycle while the output is not stalled; a byte is
//  registered in the input register and its result in the output register.
//  Both stages of the cascade are evaluated combinationally between these registers.
//  Reset clears the mode to cascade and both packing stages to empty.
//  A stalled output holds the input register; in_stall rises only then.
//  Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_von_neumann_debiaser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] raw_byte,
    input  wire logic       end_of_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      packed_byte,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_pass_mode
);

    logic [1:0]             mode_reg;
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    logic [7:0]             packed_byte_reg;
    cvnd_pkg::stage_state_t first_reg;
    cvnd_pkg::stage_state_t first_next;
    cvnd_pkg::stage_state_t second_reg;
    cvnd_pkg::stage_state_t second_next;
    logic                   res_valid_next;
    logic [7:0]             res_byte_next;

    logic                    advance;
    logic                    proc;
    logic                    first_inverted;
    logic                    cascade;
    cvnd_pkg::stage_state_t  s1_state;
    cvnd_pkg::stage_result_t s1_result;
    cvnd_pkg::stage_state_t  s2_state;
    cvnd_pkg::stage_result_t s2_result;

    // Handshake control
    assign advance   = !out_valid_reg || !out_stall;
    assign proc      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign packed_byte = packed_byte_reg;
    assign cfg_ready = 1'b1;

    // Decode the pass mode
    always_comb
    begin
        case (cvnd_pkg::pass_mode_t'(mode_reg))
            cvnd_pkg::MODE_CASCADE:
            begin
                cascade = 1'b1;
                first_inverted = 1'b1;
            end
            cvnd_pkg::MODE_INVERTED:
            begin
                cascade = 1'b0;
                first_inverted = 1'b1;
            end
            cvnd_pkg::MODE_NORMAL:
            begin
                cascade = 1'b0;
                first_inverted = 1'b0;
            end
            default:
            begin
                cascade = 1'b0;
                first_inverted = 1'b0;
            end
        endcase
    end

    // First stage works on the raw byte
    cvnd_stage u_first (
        .byte_in   (in_byte_reg),
        .inverted  (first_inverted),
        .state_in  (first_reg),
        .state_out (s1_state),
        .result    (s1_result)
    );

    // Second stage always runs the normal pass on a completed first byte
    cvnd_stage u_second (
        .byte_in   (s1_result.packed_bits),
        .inverted  (1'b0),
        .state_in  (second_reg),
        .state_out (s2_state),
        .result    (s2_result)
    );

    // Select next stage state and result for the byte in the input register
    always_comb
    begin
        first_next = s1_state;
        second_next = second_reg;
        if (cascade)
        begin
            if (s1_result.done)
            begin
                second_next = s2_state;
            end
            res_valid_next = s1_result.done && s2_result.done;
            res_byte_next = s2_result.packed_bits;
        end
        else
        begin
            res_valid_next = s1_result.done;
            res_byte_next = s1_result.packed_bits;
        end
        if (in_last_reg)
        begin
            // Drop partial bytes in both stages
            first_next = '0;
            second_next = '0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cvnd_pkg::MODE_CASCADE;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            first_reg <= '0;
            second_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_pass_mode;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && res_valid_next;
            end
            if (proc)
            begin
                first_reg <= first_next;
                second_reg <= second_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_byte_reg <= raw_byte;
            in_last_reg <= end_of_data;
        end
        if (advance)
        begin
            packed_byte_reg <= res_byte_next;
        end
    end

    // A last byte leaves both stages empty
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_last_reg |=> first_reg == '0 && second_reg == '0)
        else $error("stage state not cleared after last byte");

    // Single-stage modes leave the second stage untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && !cascade && !in_last_reg |=> $stable(second_reg))
        else $error("second stage changed outside cascade mode");

    // No result without a completed first-stage byte
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && !s1_result.done |=> !out_valid_reg)
        else $error("result without completed first-stage byte");

    // Input stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled while output free");

endmodule

`default_nettype wire

>>> tb/sv/cascaded_von_neumann_debiaser_tb.sv
// Self-checking testbench for the cascaded Von Neumann debiaser.
`timescale 1ns / 1ps

module cascaded_von_neumann_debiaser_tb;

    // Mode code that the block treats as normal only
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int IDLE_PCT        = 14;
    localparam int DRAIN_CYCLES    = 4;
    localparam int STALL_LIMIT     = 1000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int QUIET_PHASE     = 4;

    // Predicts packed bytes from accepted raw bytes and checks the output stream
    class debias_scoreboard;
        logic [1:0]             mode = cvnd_pkg::MODE_CASCADE;
        cvnd_pkg::stage_state_t first_st = '0;
        cvnd_pkg::stage_state_t second_st = '0;
        logic [7:0]             expected_bytes[$];
        int                     mismatch_count = 0;

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        function void set_mode(logic [1:0] m);
            mode = m;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Push kept bits of one byte into a stage; flag a completed byte
        function bit extract(logic [7:0] b, bit inverted,
                             inout cvnd_pkg::stage_state_t st,
                             output logic [7:0] done_byte);
            logic [1:0] pair;
            bit         got;
            got = 1'b0;
            done_byte = '0;
            for (int k = 0; k < cvnd_pkg::PAIRS_PER_BYTE; k++)
            begin
                pair = b[7 - 2 * k -: 2];
                if ((pair[1] == pair[0]) == inverted)
                begin
                    st.accum = {st.accum[6:0], pair[1]};
                    if (st.count == cvnd_pkg::COUNT_LAST)
                    begin
                        done_byte = st.accum;
                        got = 1'b1;
                        st = '0;
                    end
                    else
                    begin
                        st.count = st.count + 3'd1;
                    end
                end
            end
            return got;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [7:0] mid;
            logic [7:0] fin;
            if (mode == cvnd_pkg::MODE_CASCADE)
            begin
                if (extract(b, 1'b1, first_st, mid))
                    if (extract(mid, 1'b0, second_st, fin))
                        expected_bytes.push_back(fin);
            end
            else if (extract(b, mode == cvnd_pkg::MODE_INVERTED, first_st, fin))
            begin
                expected_bytes.push_back(fin);
            end
            // Drop partial bytes in both stages after the last byte
            if (last)
            begin
                first_st = '0;
                second_st = '0;
            end
        endfunction

        task check_byte(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected packed_byte %02h", got));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    report($sformatf("packed_byte %02h, expected %02h", got, want));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] raw_byte = '0;
    logic       end_of_data = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] packed_byte;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_pass_mode = '0;

    bit         no_idle = 1'b0;
    int         stall_cycles = 0;
    logic [1:0] phase_modes [NUM_PHASES];

    debias_scoreboard sb = new();

    cascaded_von_neumann_debiaser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_byte      (raw_byte),
        .end_of_data   (end_of_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packed_byte   (packed_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_pass_mode (cfg_pass_mode)
    );

    always #5 clk = ~clk;

    // Check each output transfer and stall the output at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_byte(packed_byte);
        out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // Count cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // End the run when the block stops moving
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one byte, idling first at random, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_byte <= b;
        end_of_data <= last;
        do @(posedge clk); while (in_stall);
        sb.note_byte(b, last);
    endtask

    // Wait until every predicted byte has come out and the pipeline is empty
    task automatic drain();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        cfg_valid <= 1'b1;
        cfg_pass_mode <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_mode(m);
    endtask

    // Mix of uniform and heavily biased bytes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 8'($urandom & $urandom);
        else if (r < 30)
            return 8'($urandom | $urandom);
        return 8'($urandom);
    endfunction

    initial
    begin
        int  left;
        int  run;
        bit  last;

        phase_modes[0] = cvnd_pkg::MODE_CASCADE;
        phase_modes[1] = cvnd_pkg::MODE_INVERTED;
        phase_modes[2] = cvnd_pkg::MODE_NORMAL;
        phase_modes[3] = MODE_UNUSED;
        phase_modes[4] = cvnd_pkg::MODE_CASCADE;
        phase_modes[5] = cvnd_pkg::MODE_NORMAL;
        phase_modes[6] = cvnd_pkg::MODE_INVERTED;
        phase_modes[7] = cvnd_pkg::MODE_CASCADE;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cascade from reset: all-equal bytes and mixed pairs, then last flag
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        in_valid <= 1'b0;
        drain();

        // Normal only: alternating pairs fill bytes quickly
        write_mode(cvnd_pkg::MODE_NORMAL);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h69, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'h66, 1'b0);
        in_valid <= 1'b0;
        drain();

        // Switch mid-stream to inverted only; first stage keeps its bits
        write_mode(cvnd_pkg::MODE_INVERTED);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        in_valid <= 1'b0;
        drain();

        // Unused mode code acts as normal only; last flag on a completing byte
        write_mode(MODE_UNUSED);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h99, 1'b0);
        send_byte(8'h66, 1'b1);
        in_valid <= 1'b0;

        // Random streams per mode, phases cut streams at arbitrary points
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_mode(phase_modes[p]);
            no_idle = (p == QUIET_PHASE);
            left = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                run = $urandom_range(8, 80);
                for (int i = 0; i < run && left > 0; i++)
                begin
                    last = (i == run - 1) || ($urandom_range(99) < 2);
                    send_byte(pick_byte(), last);
                    left--;
                end
            end
            in_valid <= 1'b0;
        end

        drain();
        if (sb.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
